>>> rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

    localparam int SLOTS_DEF      = 256;
    localparam int KEY_BYTES_DEF  = 4;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KIND_W    = 2;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 8;
    localparam int ENTRIES_W = 9;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 56;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_REMOVED = 2'd1;
    localparam logic [1:0] SLOT_USED    = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HASH  = 6'b000010,
        ST_SEED  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_CLEAR = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic seed;
        logic rd;
        logic check;
        logic clr_step;
        logic clr_done;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hash_last;
        logic probe_end;
        logic clr_last;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table controller
// Sequences hashing, probing, clearing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_valid,
    input  wire logic [oaht_pkg::KIND_W-1:0] s_kind,
    output logic                            s_ready,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    input  wire oaht_pkg::sts_t             sts,
    output oaht_pkg::cmd_t                  cmd
);

    oaht_pkg::state_t state_reg, state_next;
    logic init_reg, init_next;
    logic pend_reg, pend_next;
    logic valid_reg, valid_next;
    logic out_free;

    assign out_free = !valid_reg || m_ready;
    assign s_ready  = (state_reg == oaht_pkg::ST_IDLE) && !pend_reg;
    assign m_valid  = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        unique case (state_reg)
            oaht_pkg::ST_IDLE:
            begin
                if (pend_reg)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        pend_next    = 1'b0;
                    end
                end
                else if (s_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = (s_kind == oaht_pkg::KIND_CLEAR) ?
                                 oaht_pkg::ST_CLEAR : oaht_pkg::ST_HASH;
                end
            end
            oaht_pkg::ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                    state_next = oaht_pkg::ST_SEED;
            end
            oaht_pkg::ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = oaht_pkg::ST_READ;
            end
            oaht_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = oaht_pkg::ST_CHECK;
            end
            oaht_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.probe_end)
                begin
                    state_next = oaht_pkg::ST_IDLE;
                    pend_next  = 1'b1;
                end
                else
                    state_next = oaht_pkg::ST_READ;
            end
            oaht_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.clr_done = 1'b1;
                    state_next   = oaht_pkg::ST_IDLE;
                    pend_next    = !init_reg;
                    init_next    = 1'b0;
                end
            end
            default:
                state_next = oaht_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (m_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oaht_pkg::ST_CLEAR;
            init_reg  <= 1'b1;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/oaht_dp.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table datapath
// FNV-1a hash unit, probe index logic, slot memories and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_dp #(
    parameter int SLOTS      = oaht_pkg::SLOTS_DEF,
    parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire oaht_pkg::cmd_t                cmd,
    output oaht_pkg::sts_t                     sts,
    input  wire logic [oaht_pkg::KIND_W-1:0]   in_kind,
    input  wire logic [oaht_pkg::KEY_W-1:0]    in_key,
    input  wire logic [oaht_pkg::VALUE_W-1:0]  in_value,
    output logic [oaht_pkg::M_DATA_W-1:0]      out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = 8 * KEY_BYTES;
    localparam int BW = $clog2(KEY_BYTES) + 1;

    logic [1:0]            tag_mem [SLOTS];
    logic [KW-1:0]         key_mem [SLOTS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS];

    logic [1:0]            tag_rd_reg;
    logic [KW-1:0]         key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;

    logic [oaht_pkg::KIND_W-1:0] kind_reg;
    logic [KW-1:0]         key_reg;
    logic [KW-1:0]         key_sh_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [31:0]           hash_reg;
    logic [BW-1:0]         byte_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         n_reg;
    logic [CW-1:0]         count_reg, count_next;

    logic [oaht_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0]         res_value_reg, res_value_next;
    logic [IW-1:0]                 res_slot_reg, res_slot_next;

    logic [oaht_pkg::STATUS_W-1:0]  out_status_reg;
    logic [oaht_pkg::VALUE_W-1:0]   out_value_reg;
    logic [oaht_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [oaht_pkg::ENTRIES_W-1:0] out_entries_reg;

    logic [63:0] key_ext, val_ext, rv_ext, slot_ext, cnt_ext;
    logic [31:0] hash_mix, hash_next, hash_fix;
    logic        is_ins, is_used, is_empty, hit, last, ins_wr, rem_wr;
    logic        tag_we;
    logic [1:0]  tag_wd;

    assign key_ext  = 64'(in_key);
    assign val_ext  = 64'(in_value);
    assign hash_mix = hash_reg ^ {24'd0, key_sh_reg[7:0]};
    assign hash_next = hash_mix * oaht_pkg::FNV_PRIME;
    assign hash_fix = (hash_reg < 32'd2) ? hash_reg + 32'd2 : hash_reg;

    assign is_ins   = kind_reg == oaht_pkg::KIND_INSERT;
    assign is_used  = tag_rd_reg == oaht_pkg::SLOT_USED;
    assign is_empty = tag_rd_reg == oaht_pkg::SLOT_EMPTY;
    assign hit      = is_ins ? !is_used : (is_used && key_rd_reg == key_reg);
    assign last     = n_reg == IW'(SLOTS - 1);
    assign ins_wr   = cmd.check && is_ins && hit;
    assign rem_wr   = cmd.check && kind_reg == oaht_pkg::KIND_REMOVE && hit;

    assign sts.hash_last = byte_reg == BW'(KEY_BYTES - 1);
    assign sts.probe_end = hit || (!is_ins && is_empty) || last;
    assign sts.clr_last  = idx_reg == IW'(SLOTS - 1);

    always_comb
    begin
        tag_we = cmd.clr_step || ins_wr || rem_wr;
        if (ins_wr)
            tag_wd = oaht_pkg::SLOT_USED;
        else if (rem_wr)
            tag_wd = oaht_pkg::SLOT_REMOVED;
        else
            tag_wd = oaht_pkg::SLOT_EMPTY;
    end

    always_comb
    begin
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        if (cmd.clr_done)
        begin
            count_next      = '0;
            res_status_next = oaht_pkg::STATUS_OK;
            res_value_next  = '0;
            res_slot_next   = '0;
        end
        else if (cmd.check && sts.probe_end)
        begin
            res_status_next = hit ? oaht_pkg::STATUS_OK :
                              (is_ins ? oaht_pkg::STATUS_FULL : oaht_pkg::STATUS_NOTFOUND);
            res_slot_next   = hit ? idx_reg : '0;
            res_value_next  = (hit && kind_reg == oaht_pkg::KIND_LOOKUP) ? val_rd_reg : '0;
            if (ins_wr)
                count_next = count_reg + CW'(1);
            else if (rem_wr && count_reg != '0)
                count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            tag_rd_reg <= tag_mem[idx_reg];
            key_rd_reg <= key_mem[idx_reg];
            val_rd_reg <= val_mem[idx_reg];
        end
        if (tag_we)
            tag_mem[idx_reg] <= tag_wd;
        if (ins_wr)
        begin
            key_mem[idx_reg] <= key_reg;
            val_mem[idx_reg] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= in_kind;
            key_reg    <= key_ext[KW-1:0];
            key_sh_reg <= key_ext[KW-1:0];
            val_reg    <= val_ext[VALUE_BITS-1:0];
            hash_reg   <= oaht_pkg::FNV_OFFSET;
            byte_reg   <= '0;
        end
        if (cmd.hash_step)
        begin
            hash_reg   <= hash_next;
            key_sh_reg <= key_sh_reg >> 8;
            byte_reg   <= byte_reg + BW'(1);
        end
        if (cmd.seed)
            n_reg <= '0;
        else if (cmd.check && !sts.probe_end)
            n_reg <= n_reg + IW'(1);
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_value_reg   <= rv_ext[oaht_pkg::VALUE_W-1:0];
            out_slot_reg    <= slot_ext[oaht_pkg::SLOT_W-1:0];
            out_entries_reg <= cnt_ext[oaht_pkg::ENTRIES_W-1:0];
        end
    end

    assign rv_ext   = 64'(res_value_reg);
    assign slot_ext = 64'(res_slot_reg);
    assign cnt_ext  = 64'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load || (cmd.clr_step && sts.clr_last))
                idx_reg <= '0;
            else if (cmd.clr_step)
                idx_reg <= idx_reg + IW'(1);
            else if (cmd.seed)
                idx_reg <= hash_fix[IW-1:0];
            else if (cmd.check && !sts.probe_end)
                idx_reg <= idx_reg + n_reg + IW'(1);
        end
    end

    assign out_data = {5'd0, out_entries_reg, out_slot_reg, out_value_reg, out_status_reg};

endmodule

`default_nettype wire

>>> rtl/open_addressing_hash_table_unit.sv
// ----------------------------------------------------------------------------
// Open-addressing hash table unit
// Key-value table with FNV-1a hashing and triangular probing.
// One operation is in flight at a time.
// The next transfer is accepted in the cycle after the result register loads.
// Each probe takes a READ state for the registered slot memory read and a CHECK state for the compare.
// After reset a clearing pass empties every tag before input.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table_unit #(
    parameter int SLOTS      = oaht_pkg::SLOTS_DEF,
    parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // key[31:0], value[63:32]
    input  wire logic [oaht_pkg::S_DATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [oaht_pkg::KIND_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status[1:0], value_out[33:2], slot[41:34], entries[50:42], zero fill
    output logic [oaht_pkg::M_DATA_W-1:0]      m_axis_tdata
);

    oaht_pkg::cmd_t cmd;
    oaht_pkg::sts_t sts;

    oaht_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_kind  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    oaht_dp #(
        .SLOTS      (SLOTS),
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_kind  (s_axis_tuser),
        .in_key   (s_axis_tdata[31:0]),
        .in_value (s_axis_tdata[63:32]),
        .out_data (m_axis_tdata)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an operation is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("result carries an undefined status code");

    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 64'(m_axis_tdata[50:42]) <= 64'(SLOTS))
        else $error("entry count exceeds the slot count");

endmodule

`default_nettype wire
